/* hw/rtl/lruwb_pkg.sv */
// ----------------------------------------------------------------------------
// lruwb_pkg: shared types and constants of the LRU write-back cache
// Field widths, request and result codes, controller states and the
// per-cell control word.
// ----------------------------------------------------------------------------
package lruwb_pkg;

	localparam int CAPACITY_DEF   = 8;
	localparam int KEY_BITS_DEF   = 32;
	localparam int VALUE_BITS_DEF = 32;

	localparam int FIELD_W = 32;
	localparam int CNT_W   = 16;
	localparam int CFG_W   = 4;

	localparam logic [CFG_W-1:0] CAP_RESET = 4'd8;
	localparam logic [CNT_W-1:0] CNT_MAX   = 16'hFFFF;

	typedef enum logic [1:0] {
		MODE_GET   = 2'd0,
		MODE_SET   = 2'd1,
		MODE_FILL  = 2'd2,
		MODE_FLUSH = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		KIND_HIT  = 2'd0,
		KIND_MISS = 2'd1,
		KIND_WB   = 2'd2,
		KIND_DONE = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOK,
		ST_ACK,
		ST_FLUSH
	} state_t;

	typedef struct packed {
		logic shift;
		logic load;
	} cell_ctrl_t;

endpackage

/* hw/rtl/lruwb_cell.sv */
// ----------------------------------------------------------------------------
// lruwb_cell: one slot of the recency chain
// Holds key, value and dirty flag, compares its key against the lookup key,
// and either loads broadcast data or takes its newer neighbor's entry.
// ----------------------------------------------------------------------------
module lruwb_cell
	import lruwb_pkg::*;
#(
	parameter int KEY_BITS   = KEY_BITS_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cell_ctrl_t            ctrl,
	input  logic                  in_use,
	input  logic [KEY_BITS-1:0]   cmp_key,
	input  logic [KEY_BITS-1:0]   nbr_key,
	input  logic [VALUE_BITS-1:0] nbr_val,
	input  logic                  nbr_dirty,
	input  logic [KEY_BITS-1:0]   ld_key,
	input  logic [VALUE_BITS-1:0] ld_val,
	input  logic                  ld_dirty,
	output logic [KEY_BITS-1:0]   key,
	output logic [VALUE_BITS-1:0] val,
	output logic                  dirty,
	output logic                  hit
);

	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] val_q;
	logic                  dirty_q;

	always_ff @(posedge clk) begin
		priority if (ctrl.load) begin
			key_q <= ld_key;
			val_q <= ld_val;
		end else if (ctrl.shift) begin
			key_q <= nbr_key;
			val_q <= nbr_val;
		end else begin
			key_q <= key_q;
			val_q <= val_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dirty_q <= 1'b0;
		end else begin
			priority if (ctrl.load) begin
				dirty_q <= ld_dirty;
			end else if (ctrl.shift) begin
				dirty_q <= nbr_dirty;
			end else begin
				dirty_q <= dirty_q;
			end
		end
	end

	assign key   = key_q;
	assign val   = val_q;
	assign dirty = dirty_q;
	assign hit   = in_use && (key_q == cmp_key);

endmodule

/* hw/rtl/lru_writeback_kv_cache_unit.sv */
// ----------------------------------------------------------------------------
// lru_writeback_kv_cache_unit: fully associative LRU write-back key/value cache
// Chain of slot cells, oldest entry in cell 0, newest at the top of the
// occupied range; a controller steers shifts and loads along the chain.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on start/mode/key_in/value_in, taken at a clock edge where
//   start is high and busy is low. Each result appears for one cycle with
//   result_valid high; the receiver cannot hold it off. last_result marks the
//   final result of a request. cfg_we/cfg_data write capacity_in_use; write
//   it only while the unit is idle.
//   Sequence: the request is latched, then all cells compare their keys and the
//   chain shifts in the same cycle; a dirty victim adds a writeback result
//   before the final one. The result is registered and shows in the cycle
//   after the decision; the next request may be taken meanwhile.
//   Flush walks the chain one slot per cycle.
//   Reset empties the cache, clears dirty flags and the replacement count
//   and sets capacity_in_use to 8.
// ----------------------------------------------------------------------------
module lru_writeback_kv_cache_unit
	import lruwb_pkg::*;
#(
	parameter int CAPACITY   = CAPACITY_DEF,
	parameter int KEY_BITS   = KEY_BITS_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         mode,
	input  logic [FIELD_W-1:0] key_in,
	input  logic [FIELD_W-1:0] value_in,
	input  logic               cfg_we,
	input  logic [CFG_W-1:0]   cfg_data,
	output logic               result_valid,
	output logic [1:0]         result_kind,
	output logic [FIELD_W-1:0] key_out,
	output logic [FIELD_W-1:0] value_out,
	output logic [CNT_W-1:0]   eviction_count,
	output logic               last_result
);

	localparam int OW = $clog2(CAPACITY + 1);
	localparam int EW = (OW > CFG_W) ? OW : CFG_W;

	state_t state_q, state_d;

	mode_t                 mode_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] val_q;

	logic [OW-1:0]    occ_q, occ_d;
	logic [OW-1:0]    fcnt_q, fcnt_d;
	logic [CNT_W-1:0] evc_q, evc_d;
	logic [CFG_W-1:0] cap_q;

	logic               res_valid_q, res_valid_d;
	kind_t              res_kind_q, res_kind_d;
	logic [FIELD_W-1:0] res_key_q, res_key_d;
	logic [FIELD_W-1:0] res_val_q, res_val_d;
	logic [CNT_W-1:0]   res_cnt_q, res_cnt_d;
	logic               res_last_q, res_last_d;

	logic [KEY_BITS-1:0]   c_key   [CAPACITY];
	logic [VALUE_BITS-1:0] c_val   [CAPACITY];
	logic [CAPACITY-1:0]   c_dirty;
	logic [CAPACITY-1:0]   hit_vec;
	logic [CAPACITY-1:0]   pre_hit;
	logic [CAPACITY-1:0]   in_use;
	logic [CAPACITY-1:0]   below_top;
	logic [CAPACITY-1:0]   is_top;
	logic [CAPACITY-1:0]   is_next;
	cell_ctrl_t            ctrl [CAPACITY];

	logic [KEY_BITS-1:0]   ld_key;
	logic [VALUE_BITS-1:0] ld_val;
	logic                  ld_dirty;

	logic                  any_hit;
	logic [KEY_BITS-1:0]   sel_key;
	logic [VALUE_BITS-1:0] sel_val;
	logic                  sel_dirty;
	logic [EW-1:0]         eff_cap;
	logic                  full;
	logic [CNT_W-1:0]      evc_inc;

	// ------------------------------------------------------------------
	// Cell chain
	// ------------------------------------------------------------------
	for (genvar j = 0; j < CAPACITY; j++) begin : g_cell
		localparam logic [OW:0] IDX = (OW+1)'(j);

		logic [KEY_BITS-1:0]   nbr_key;
		logic [VALUE_BITS-1:0] nbr_val;
		logic                  nbr_dirty;

		if (j == CAPACITY - 1) begin : g_end
			assign nbr_key   = '0;
			assign nbr_val   = '0;
			assign nbr_dirty = 1'b0;
		end else begin : g_mid
			assign nbr_key   = c_key[j+1];
			assign nbr_val   = c_val[j+1];
			assign nbr_dirty = c_dirty[j+1];
		end

		assign in_use[j]    = IDX < {1'b0, occ_q};
		assign below_top[j] = (IDX + 1'b1) < {1'b0, occ_q};
		assign is_top[j]    = (IDX + 1'b1) == {1'b0, occ_q};
		assign is_next[j]   = IDX == {1'b0, occ_q};
		assign pre_hit[j]   = |hit_vec[j:0];

		lruwb_cell #(
			.KEY_BITS   (KEY_BITS),
			.VALUE_BITS (VALUE_BITS)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl[j]),
			.in_use    (in_use[j]),
			.cmp_key   (key_q),
			.nbr_key   (nbr_key),
			.nbr_val   (nbr_val),
			.nbr_dirty (nbr_dirty),
			.ld_key    (ld_key),
			.ld_val    (ld_val),
			.ld_dirty  (ld_dirty),
			.key       (c_key[j]),
			.val       (c_val[j]),
			.dirty     (c_dirty[j]),
			.hit       (hit_vec[j])
		);
	end

	// Matching entry; keys are unique within the occupied range
	always_comb begin
		sel_key   = '0;
		sel_val   = '0;
		sel_dirty = 1'b0;
		for (int j = 0; j < CAPACITY; j++) begin
			sel_key   = sel_key   | (c_key[j] & {KEY_BITS{hit_vec[j]}});
			sel_val   = sel_val   | (c_val[j] & {VALUE_BITS{hit_vec[j]}});
			sel_dirty = sel_dirty | (c_dirty[j] & hit_vec[j]);
		end
	end

	assign any_hit = |hit_vec;

	always_comb begin
		if (cap_q == '0) begin
			eff_cap = EW'(1);
		end else if (EW'(cap_q) > EW'(CAPACITY)) begin
			eff_cap = EW'(CAPACITY);
		end else begin
			eff_cap = EW'(cap_q);
		end
	end

	assign full    = EW'(occ_q) >= eff_cap;
	assign evc_inc = (evc_q == CNT_MAX) ? evc_q : evc_q + 1'b1;

	// ------------------------------------------------------------------
	// Controller
	// ------------------------------------------------------------------
	always_comb begin
		state_d     = state_q;
		occ_d       = occ_q;
		fcnt_d      = fcnt_q;
		evc_d       = evc_q;
		res_valid_d = 1'b0;
		res_kind_d  = KIND_DONE;
		res_key_d   = '0;
		res_val_d   = '0;
		res_cnt_d   = evc_q;
		res_last_d  = 1'b1;
		ld_key      = key_q;
		ld_val      = val_q;
		ld_dirty    = 1'b0;
		for (int j = 0; j < CAPACITY; j++) begin
			ctrl[j] = '0;
		end

		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_LOOK;
				end
			end

			ST_LOOK: begin
				state_d     = ST_IDLE;
				res_valid_d = 1'b1;
				if (mode_q == MODE_FLUSH) begin
					res_valid_d = 1'b0;
					fcnt_d      = occ_q;
					state_d     = ST_FLUSH;
				end else if (any_hit) begin
					// get and set promote: slide newer entries down, matched one to the top
					if (mode_q != MODE_FILL) begin
						ld_key   = sel_key;
						ld_val   = (mode_q == MODE_SET) ? val_q : sel_val;
						ld_dirty = (mode_q == MODE_SET) ? 1'b1 : sel_dirty;
						for (int j = 0; j < CAPACITY; j++) begin
							ctrl[j].shift = pre_hit[j] && below_top[j];
							ctrl[j].load  = is_top[j];
						end
					end
					if (mode_q == MODE_GET) begin
						res_kind_d = KIND_HIT;
						res_key_d  = FIELD_W'(sel_key);
						res_val_d  = FIELD_W'(sel_val);
					end
				end else if (mode_q == MODE_GET) begin
					res_kind_d = KIND_MISS;
					res_key_d  = FIELD_W'(key_q);
				end else begin
					ld_dirty = (mode_q == MODE_SET);
					if (full) begin
						// drop the oldest entry, shift the rest down
						for (int j = 0; j < CAPACITY; j++) begin
							ctrl[j].shift = below_top[j];
							ctrl[j].load  = is_top[j];
						end
						if (c_dirty[0]) begin
							evc_d      = evc_inc;
							res_kind_d = KIND_WB;
							res_key_d  = FIELD_W'(c_key[0]);
							res_val_d  = FIELD_W'(c_val[0]);
							res_cnt_d  = evc_inc;
							res_last_d = 1'b0;
							state_d    = ST_ACK;
						end
					end else begin
						occ_d = occ_q + 1'b1;
						for (int j = 0; j < CAPACITY; j++) begin
							ctrl[j].load = is_next[j];
						end
					end
				end
			end

			ST_ACK: begin
				res_valid_d = 1'b1;
				state_d     = ST_IDLE;
			end

			ST_FLUSH: begin
				res_cnt_d = '0;
				if (fcnt_q == '0) begin
					res_valid_d = 1'b1;
					occ_d       = '0;
					evc_d       = '0;
					state_d     = ST_IDLE;
				end else begin
					// walk oldest first: report cell 0 when dirty, advance the chain
					fcnt_d = fcnt_q - 1'b1;
					for (int j = 0; j < CAPACITY; j++) begin
						ctrl[j].shift = 1'b1;
					end
					if (c_dirty[0]) begin
						res_valid_d = 1'b1;
						res_kind_d  = KIND_WB;
						res_key_d   = FIELD_W'(c_key[0]);
						res_val_d   = FIELD_W'(c_val[0]);
						res_last_d  = 1'b0;
					end
				end
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			occ_q       <= '0;
			fcnt_q      <= '0;
			evc_q       <= '0;
			cap_q       <= CAP_RESET;
			res_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			occ_q       <= occ_d;
			fcnt_q      <= fcnt_d;
			evc_q       <= evc_d;
			res_valid_q <= res_valid_d;
			if (cfg_we) begin
				cap_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			mode_q <= mode_t'(mode);
			key_q  <= KEY_BITS'(key_in);
			val_q  <= VALUE_BITS'(value_in);
		end
		res_kind_q <= res_kind_d;
		res_key_q  <= res_key_d;
		res_val_q  <= res_val_d;
		res_cnt_q  <= res_cnt_d;
		res_last_q <= res_last_d;
	end

	assign busy           = (state_q != ST_IDLE);
	assign result_valid   = res_valid_q;
	assign result_kind    = res_kind_q;
	assign key_out        = res_key_q;
	assign value_out      = res_val_q;
	assign eviction_count = res_cnt_q;
	assign last_result    = res_last_q;

endmodule

/* dv/lru_writeback_kv_cache_unit_tb.sv */
// ----------------------------------------------------------------------------
// lru_writeback_kv_cache_unit_tb: self-checking bench for the LRU write-back cache
// Drives get, set, fill and flush requests through the start/busy handshake
// and keeps a recency-ordered shadow copy of the cache to predict every hit,
// read request, writeback and acknowledge. A directed table comes first, then
// random traffic over several capacity settings, with a short run of dirty
// replacements at capacity one before the last random phase.
// ----------------------------------------------------------------------------
module lru_writeback_kv_cache_unit_tb;
	import lruwb_pkg::*;

	localparam int CYCLE_LIMIT     = 100_000;
	localparam int SETTLE_CYCLES   = 12;
	localparam int RESET_CYCLES    = 12;
	localparam int MAX_REPORTS     = 30;
	localparam int KEY_POOL        = 10;
	localparam int PHASE_ITEMS     = 16;
	localparam int RANDOM_PHASES   = 8;
	localparam int SATURATION_SETS = 12;

	typedef struct packed {
		kind_t             kind;
		logic [31:0]       key;
		logic [31:0]       value;
		logic [CNT_W-1:0]  count;
		logic              last;
	} cache_response_t;

	typedef struct packed {
		logic              cfg;
		mode_t             op;
		logic [31:0]       key;
		logic [31:0]       value;
		logic              typed;
		kind_t             xkind;
		logic [31:0]       xkey;
		logic [31:0]       xvalue;
		logic [CNT_W-1:0]  xcount;
	} directed_row_t;

	localparam cache_response_t NO_RESPONSE = '{KIND_HIT, 32'h0, 32'h0, 16'h0, 1'b0};

	// cfg rows carry the capacity in the value column
	localparam directed_row_t DIRECTED_ROWS [27] = '{
		'{1'b0, MODE_GET,   32'h0000_0000, 32'h0000_0000, 1'b1, KIND_MISS, 32'h0000_0000,
			32'h0000_0000, 16'h0},
		'{1'b0, MODE_GET,   32'hFFFF_FFFF, 32'h0000_0000, 1'b1, KIND_MISS, 32'hFFFF_FFFF,
			32'h0000_0000, 16'h0},
		'{1'b0, MODE_FILL,  32'h0000_0000, 32'hFFFF_FFFF, 1'b1, KIND_DONE, 32'h0000_0000,
			32'h0000_0000, 16'h0},
		'{1'b0, MODE_GET,   32'h0000_0000, 32'h0000_0000, 1'b1, KIND_HIT,  32'h0000_0000,
			32'hFFFF_FFFF, 16'h0},
		'{1'b0, MODE_SET,   32'hFFFF_FFFF, 32'h0000_0000, 1'b1, KIND_DONE, 32'h0000_0000,
			32'h0000_0000, 16'h0},
		'{1'b0, MODE_SET,   32'hFFFF_FFFF, 32'hA5A5_A5A5, 1'b1, KIND_DONE, 32'h0000_0000,
			32'h0000_0000, 16'h0},
		'{1'b0, MODE_FILL,  32'hFFFF_FFFF, 32'h1234_5678, 1'b1, KIND_DONE, 32'h0000_0000,
			32'h0000_0000, 16'h0},
		'{1'b0, MODE_GET,   32'hFFFF_FFFF, 32'h0000_0000, 1'b1, KIND_HIT,  32'hFFFF_FFFF,
			32'hA5A5_A5A5, 16'h0},
		'{1'b0, MODE_FLUSH, 32'h0000_0000, 32'h0000_0000, 1'b0, KIND_HIT,  32'h0, 32'h0, 16'h0},
		'{1'b0, MODE_FLUSH, 32'h0000_0000, 32'h0000_0000, 1'b1, KIND_DONE, 32'h0000_0000,
			32'h0000_0000, 16'h0},
		'{1'b1, MODE_GET,   32'h0, 32'h1, 1'b0, KIND_HIT, 32'h0, 32'h0, 16'h0},
		'{1'b0, MODE_SET,   32'h11, 32'h1, 1'b0, KIND_HIT, 32'h0, 32'h0, 16'h0},
		'{1'b0, MODE_SET,   32'h22, 32'h2, 1'b0, KIND_HIT, 32'h0, 32'h0, 16'h0},
		'{1'b0, MODE_FILL,  32'h33, 32'h3, 1'b0, KIND_HIT, 32'h0, 32'h0, 16'h0},
		'{1'b0, MODE_FILL,  32'h44, 32'h4, 1'b0, KIND_HIT, 32'h0, 32'h0, 16'h0},
		'{1'b1, MODE_GET,   32'h0, 32'h0, 1'b0, KIND_HIT, 32'h0, 32'h0, 16'h0},
		'{1'b0, MODE_SET,   32'h55, 32'h5, 1'b0, KIND_HIT, 32'h0, 32'h0, 16'h0},
		'{1'b1, MODE_GET,   32'h0, 32'hF, 1'b0, KIND_HIT, 32'h0, 32'h0, 16'h0},
		'{1'b0, MODE_FILL,  32'h66, 32'h6, 1'b0, KIND_HIT, 32'h0, 32'h0, 16'h0},
		'{1'b0, MODE_SET,   32'h77, 32'h7, 1'b0, KIND_HIT, 32'h0, 32'h0, 16'h0},
		'{1'b0, MODE_SET,   32'h88, 32'h8, 1'b0, KIND_HIT, 32'h0, 32'h0, 16'h0},
		'{1'b1, MODE_GET,   32'h0, 32'h2, 1'b0, KIND_HIT, 32'h0, 32'h0, 16'h0},
		'{1'b0, MODE_FILL,  32'h99, 32'h9, 1'b0, KIND_HIT, 32'h0, 32'h0, 16'h0},
		'{1'b0, MODE_GET,   32'h66, 32'h0, 1'b0, KIND_HIT, 32'h0, 32'h0, 16'h0},
		'{1'b0, MODE_SET,   32'hAA, 32'hA, 1'b0, KIND_HIT, 32'h0, 32'h0, 16'h0},
		'{1'b0, MODE_FLUSH, 32'h0, 32'h0, 1'b0, KIND_HIT, 32'h0, 32'h0, 16'h0},
		'{1'b1, MODE_GET,   32'h0, 32'h8, 1'b0, KIND_HIT, 32'h0, 32'h0, 16'h0}
	};

	localparam logic [CFG_W-1:0] RANDOM_CAPS [RANDOM_PHASES] = '{
		4'd8, 4'd3, 4'd1, 4'd0, 4'd15, 4'd5, 4'd2, 4'd8
	};

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [1:0]         mode;
	logic [FIELD_W-1:0] key_in;
	logic [FIELD_W-1:0] value_in;
	logic               cfg_we;
	logic [CFG_W-1:0]   cfg_data;
	logic               result_valid;
	logic [1:0]         result_kind;
	logic [FIELD_W-1:0] key_out;
	logic [FIELD_W-1:0] value_out;
	logic [CNT_W-1:0]   eviction_count;
	logic               last_result;

	// shadow cache: slot 0 oldest, slot occupancy-1 newest
	logic [31:0]        slot_key [CAPACITY_DEF];
	logic [31:0]        slot_value [CAPACITY_DEF];
	logic               slot_dirty [CAPACITY_DEF] = '{default: 1'b0};
	int                 occupancy = 0;
	logic [CNT_W-1:0]   replacements = '0;
	logic [CFG_W-1:0]   capacity_reg = CAP_RESET;

	cache_response_t    step_responses [$];
	cache_response_t    cache_responses_due [$];

	bit                 gaps_enabled = 1'b0;
	int                 error_count = 0;
	int                 cycle_count = 0;
	int                 responses_checked = 0;
	int                 writebacks_checked = 0;
	int                 capacity_writes = 0;
	int                 peak_count = 0;
	int                 requests_by_mode [4] = '{default: 0};

	lru_writeback_kv_cache_unit dut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) cycle_count <= cycle_count + 1;

	function automatic int find_entry(logic [31:0] k);
		for (int i = 0; i < occupancy && i < CAPACITY_DEF; i++)
			if (slot_key[i] == k)
				return i;
		return -1;
	endfunction

	function automatic void queue_response(kind_t kind, logic [31:0] k, logic [31:0] v);
		step_responses.push_back('{kind, k, v, 16'h0, 1'b0});
	endfunction

	function automatic void move_to_newest(int i);
		logic [31:0] k;
		logic [31:0] v;
		logic        d;
		k = slot_key[i];
		v = slot_value[i];
		d = slot_dirty[i];
		for (int j = i; j + 1 < occupancy; j++) begin
			slot_key[j]   = slot_key[j+1];
			slot_value[j] = slot_value[j+1];
			slot_dirty[j] = slot_dirty[j+1];
		end
		slot_key[occupancy-1]   = k;
		slot_value[occupancy-1] = v;
		slot_dirty[occupancy-1] = d;
	endfunction

	function automatic void insert_entry(logic [31:0] k, logic [31:0] v, logic d);
		int cap;
		cap = (capacity_reg == 0) ? 1 :
			(capacity_reg > CAPACITY_DEF) ? CAPACITY_DEF : int'(capacity_reg);
		if (occupancy >= cap) begin
			// drop the oldest entry; a dirty one goes back to the backing store
			if (slot_dirty[0]) begin
				queue_response(KIND_WB, slot_key[0], slot_value[0]);
				if (replacements != CNT_MAX)
					replacements++;
			end
			for (int j = 0; j + 1 < occupancy; j++) begin
				slot_key[j]   = slot_key[j+1];
				slot_value[j] = slot_value[j+1];
				slot_dirty[j] = slot_dirty[j+1];
			end
		end else begin
			occupancy++;
		end
		slot_key[occupancy-1]   = k;
		slot_value[occupancy-1] = v;
		slot_dirty[occupancy-1] = d;
	endfunction

	// Update the shadow cache for one request and list the responses it causes.
	function automatic void apply_cache_request(mode_t m, logic [31:0] k, logic [31:0] v);
		int slot;
		step_responses.delete();
		slot = find_entry(k);
		case (m)
			MODE_GET: begin
				if (slot >= 0) begin
					queue_response(KIND_HIT, slot_key[slot], slot_value[slot]);
					move_to_newest(slot);
				end else begin
					queue_response(KIND_MISS, k, 32'h0);
				end
			end
			MODE_SET: begin
				if (slot >= 0) begin
					slot_value[slot] = v;
					slot_dirty[slot] = 1'b1;
					move_to_newest(slot);
				end else begin
					insert_entry(k, v, 1'b1);
				end
				queue_response(KIND_DONE, 32'h0, 32'h0);
			end
			MODE_FILL: begin
				if (slot < 0)
					insert_entry(k, v, 1'b0);
				queue_response(KIND_DONE, 32'h0, 32'h0);
			end
			default: begin
				for (int j = 0; j < occupancy; j++) begin
					if (slot_dirty[j]) begin
						queue_response(KIND_WB, slot_key[j], slot_value[j]);
						slot_dirty[j] = 1'b0;
					end
				end
				occupancy = 0;
				replacements = '0;
				queue_response(KIND_DONE, 32'h0, 32'h0);
			end
		endcase
		// every response of a request carries the final count
		foreach (step_responses[i]) begin
			step_responses[i].count = replacements;
			step_responses[i].last  = (i == step_responses.size() - 1);
		end
		if (int'(replacements) > peak_count)
			peak_count = int'(replacements);
		requests_by_mode[m]++;
	endfunction

	// Issue one request and hold it until the unit takes it; start stays high
	// afterwards so a back-to-back request keeps the line asserted.
	task automatic send_request(input mode_t m, input logic [31:0] k, input logic [31:0] v,
			input bit typed, input cache_response_t typed_resp);
		if (gaps_enabled && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		start    <= 1'b1;
		mode     <= m;
		key_in   <= k;
		value_in <= v;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
		apply_cache_request(m, k, v);
		if (typed)
			cache_responses_due.push_back(typed_resp);
		else
			foreach (step_responses[i])
				cache_responses_due.push_back(step_responses[i]);
	endtask

	task automatic set_capacity(input logic [CFG_W-1:0] cap);
		start <= 1'b0;
		while (cache_responses_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we   <= 1'b1;
		cfg_data <= cap;
		@(posedge clk);
		cfg_we <= 1'b0;
		capacity_reg = cap;
		capacity_writes++;
	endtask

	task automatic run_random(input int items);
		logic [31:0] pool [KEY_POOL];
		logic [31:0] k;
		int          pick;
		int          n;
		foreach (pool[i])
			pool[i] = $urandom;
		n = 0;
		while (n < items) begin
			pick = $urandom_range(0, 99);
			k = ($urandom_range(0, 7) == 0) ? $urandom : pool[$urandom_range(0, KEY_POOL - 1)];
			if (pick < 45) begin
				send_request(MODE_GET, k, $urandom, 1'b0, NO_RESPONSE);
				// answer most misses with the backing-store fill, as a host would
				if (find_entry(k) < 0 && $urandom_range(0, 3) != 0) begin
					send_request(MODE_FILL, k, $urandom, 1'b0, NO_RESPONSE);
					n++;
				end
			end else if (pick < 72) begin
				send_request(MODE_SET, k, $urandom, 1'b0, NO_RESPONSE);
			end else if (pick < 95) begin
				send_request(MODE_FILL, k, $urandom, 1'b0, NO_RESPONSE);
			end else begin
				send_request(MODE_FLUSH, $urandom, $urandom, 1'b0, NO_RESPONSE);
			end
			n++;
		end
	endtask

	task automatic check_field(input string what, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			error_count++;
			if (error_count <= MAX_REPORTS)
				$display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
		end
	endtask

	always @(posedge clk) begin
		cache_response_t want;
		if (arst_n === 1'b1 && result_valid === 1'b1) begin
			if (cache_responses_due.size() == 0) begin
				error_count++;
				if (error_count <= MAX_REPORTS)
					$display("%0t: unexpected response, expected none, actual kind %0d key %h value %h",
						$time, result_kind, key_out, value_out);
			end else begin
				want = cache_responses_due.pop_front();
				check_field("result_kind", want.kind, result_kind);
				check_field("key_out", want.key, key_out);
				check_field("value_out", want.value, value_out);
				check_field("eviction_count", want.count, eviction_count);
				check_field("last_result", want.last, last_result);
				responses_checked++;
				if (want.kind == KIND_WB)
					writebacks_checked++;
			end
		end
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("%0t: timeout after %0d cycles, %0d responses outstanding", $time,
			cycle_count, cache_responses_due.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		logic [CFG_W-1:0] cap;
		arst_n   <= 1'b0;
		start    <= 1'b0;
		mode     <= MODE_GET;
		key_in   <= '0;
		value_in <= '0;
		cfg_we   <= 1'b0;
		cfg_data <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED_ROWS[r]) begin
			if (DIRECTED_ROWS[r].cfg)
				set_capacity(DIRECTED_ROWS[r].value[CFG_W-1:0]);
			else
				send_request(DIRECTED_ROWS[r].op, DIRECTED_ROWS[r].key, DIRECTED_ROWS[r].value,
					DIRECTED_ROWS[r].typed, cache_response_t'{DIRECTED_ROWS[r].xkind,
					DIRECTED_ROWS[r].xkey, DIRECTED_ROWS[r].xvalue, DIRECTED_ROWS[r].xcount, 1'b1});
		end

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			if (phase == RANDOM_PHASES - 1) begin
				// capacity one: each set of a new key into a full cache evicts the oldest entry
				gaps_enabled = 1'b0;
				set_capacity(4'd1);
				for (int i = 0; i < SATURATION_SETS; i++)
					send_request(MODE_SET, 32'h8000_0000 | i, $urandom, 1'b0, NO_RESPONSE);
			end
			cap = (phase == 5) ? CFG_W'($urandom_range(1, CAPACITY_DEF)) : RANDOM_CAPS[phase];
			set_capacity(cap);
			gaps_enabled = (phase < RANDOM_PHASES - 2) && (phase != 2);
			run_random(PHASE_ITEMS);
		end

		start <= 1'b0;
		while (cache_responses_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Covered %0d get, %0d set, %0d fill and %0d flush requests over %0d capacity writes",
			requests_by_mode[MODE_GET], requests_by_mode[MODE_SET], requests_by_mode[MODE_FILL],
			requests_by_mode[MODE_FLUSH], capacity_writes);
		$display("Checked %0d responses, %0d of them writebacks; replacement count peaked at %0d",
			responses_checked, writebacks_checked, peak_count);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
